// ===== sv/cmap_pkg.sv =====
package cmap_pkg;

  localparam int unsigned LevelWidth = 18;
  localparam int unsigned Q16Width   = 17;
  localparam int unsigned FracWidth  = 15;
  localparam int unsigned KeyWidth   = 16;
  localparam int unsigned ProdWidth  = KeyWidth + FracWidth;
  localparam int unsigned NumChan    = 3;

  localparam logic [Q16Width-1:0]  OneQ16  = 17'd65536;
  localparam logic [Q16Width-1:0]  HalfQ16 = 17'd32768;
  localparam logic [FracWidth-1:0] OneQ14  = 15'd16384;

  localparam logic MapViridis  = 1'b0;
  localparam logic MapCoolwarm = 1'b1;

  localparam logic [1:0] ChanRed   = 2'd0;
  localparam logic [1:0] ChanGreen = 2'd1;
  localparam logic [1:0] ChanBlue  = 2'd2;

  typedef logic [Q16Width-1:0]  q16_t;
  typedef logic [ProdWidth-1:0] prod_t;
  typedef logic [7:0]           byte_t;

  // Payload handed from the blend stage to the quantising stage.
  typedef struct packed {
    logic                   mode;
    prod_t [NumChan-1:0]    prod_lo;
    prod_t [NumChan-1:0]    prod_hi;
    q16_t  [NumChan-1:0]    cw;
  } blend_t;

  // Viridis key colours in Q16, rows are keys, channel order red, green, blue.
  function automatic logic [KeyWidth-1:0] vir_key(input logic [2:0] k, input logic [1:0] ch);
    logic [KeyWidth-1:0] v;
    v = '0;
    case ({k, ch})
      {3'd0, ChanRed}:   v = 16'd17498;
      {3'd0, ChanGreen}: v = 16'd328;
      {3'd0, ChanBlue}:  v = 16'd21561;
      {3'd1, ChanRed}:   v = 16'd15139;
      {3'd1, ChanGreen}: v = 16'd21103;
      {3'd1, ChanBlue}:  v = 16'd35717;
      {3'd2, ChanRed}:   v = 16'd8454;
      {3'd2, ChanGreen}: v = 16'd37290;
      {3'd2, ChanBlue}:  v = 16'd35979;
      {3'd3, ChanRed}:   v = 16'd24183;
      {3'd3, ChanGreen}: v = 16'd51642;
      {3'd3, ChanBlue}:  v = 16'd25166;
      {3'd4, ChanRed}:   v = 16'd65077;
      {3'd4, ChanGreen}: v = 16'd59376;
      {3'd4, ChanBlue}:  v = 16'd9503;
      default:           v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/cmap_front.sv =====
module cmap_front (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [cmap_pkg::LevelWidth-1:0] level,
  input  logic                                 mode,
  output cmap_pkg::q16_t                       t_r,
  output logic                                 mode_r
);
  import cmap_pkg::*;

  q16_t t_nxt;

  // Negative values go to zero, anything above one saturates at one.
  always_comb begin
    if (level[LevelWidth-1]) begin
      t_nxt = '0;
    end else if (level[LevelWidth-2:0] > OneQ16) begin
      t_nxt = OneQ16;
    end else begin
      t_nxt = level[Q16Width-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r    <= t_nxt;
      mode_r <= mode;
    end
  end

endmodule

// ===== sv/cmap_blend.sv =====
module cmap_blend (
  input  logic             clk,
  input  logic             en,
  input  cmap_pkg::q16_t   t,
  input  logic             mode,
  output cmap_pkg::blend_t blend_r
);
  import cmap_pkg::*;

  logic [2:0]           k;
  q16_t                 f_full;
  logic [FracWidth-1:0] f;
  logic [FracWidth-1:0] wf;
  q16_t                 s_hi;
  q16_t                 cw_c;
  blend_t               blend_nxt;

  always_comb begin
    k = (t[16:14] > 3'd3) ? 3'd3 : t[16:14];
    f_full = t - {k[1:0], 14'd0};
    f  = f_full[FracWidth-1:0];
    wf = OneQ14 - f;
    s_hi = (t - HalfQ16) << 1;
    blend_nxt.mode = mode;
    for (int ch = 0; ch < NumChan; ch++) begin
      blend_nxt.prod_lo[ch] = vir_key(k, 2'(ch)) * wf;
      blend_nxt.prod_hi[ch] = vir_key(k + 3'd1, 2'(ch)) * f;
    end
    if (t < HalfQ16) begin
      cw_c = {t[15:0], 1'b0};
      blend_nxt.cw[ChanRed]   = cw_c;
      blend_nxt.cw[ChanGreen] = cw_c;
      blend_nxt.cw[ChanBlue]  = OneQ16;
    end else begin
      cw_c = OneQ16 - s_hi;
      blend_nxt.cw[ChanRed]   = OneQ16;
      blend_nxt.cw[ChanGreen] = cw_c;
      blend_nxt.cw[ChanBlue]  = cw_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      blend_r <= blend_nxt;
    end
  end

endmodule

// ===== sv/cmap_quant.sv =====
module cmap_quant (
  input  logic             clk,
  input  logic             en,
  input  cmap_pkg::blend_t blend,
  output cmap_pkg::byte_t  red_r,
  output cmap_pkg::byte_t  green_r,
  output cmap_pkg::byte_t  blue_r,
  output logic             mode_r
);
  import cmap_pkg::*;

  byte_t [NumChan-1:0] chan_nxt;

  always_comb begin
    logic [ProdWidth:0] sum;
    q16_t               q;
    logic [24:0]        scaled;
    for (int ch = 0; ch < NumChan; ch++) begin
      sum = {1'b0, blend.prod_lo[ch]} + {1'b0, blend.prod_hi[ch]};
      if (blend.mode == MapCoolwarm) begin
        q = blend.cw[ch];
      end else if (sum[ProdWidth:14] > {1'b0, OneQ16}) begin
        q = OneQ16;
      end else begin
        q = sum[30:14];
      end
      // Times 255 is a shift and a subtract.
      scaled = {q, 8'd0} - {8'd0, q};
      chan_nxt[ch] = scaled[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_r   <= chan_nxt[ChanRed];
      green_r <= chan_nxt[ChanGreen];
      blue_r  <= chan_nxt[ChanBlue];
      mode_r  <= blend.mode;
    end
  end

endmodule

// ===== sv/scalar_to_rgb_colormap_unit.sv =====
// An accepted input word passes through the front, blend and quant stage registers to the output.
// Throughput: one word per clock while out_tready is high; each of the three stages holds one word.
// The output register advances whenever it is empty or being read, and a
// bubble in any stage is squeezed out as the stage behind it moves forward.
// Reset (rst_n low, synchronous) empties the pipeline and selects viridis mode.
module scalar_to_rgb_colormap_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write: map_select in bit 0.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [17:0] level (signed Q2.16), [23:18] zero
  // Output stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [7:0] red, [15:8] green, [23:16] blue
);
  import cmap_pkg::*;

  // The single map mode register is to change only while idle (the block does not
  // enforce it); each word carries its mode, so every stage sees its own word's mode.
  logic   map_select_r;
  logic   map_select_nxt;

  // Valid bits of the three stages; the last one is the output register.
  logic   s1_valid_r, s1_valid_nxt;
  logic   s2_valid_r, s2_valid_nxt;
  logic   s3_valid_r, s3_valid_nxt;

  // A stage may load when it is empty or when its contents are moving on.
  logic   s1_en, s2_en, s3_en;

  q16_t   t_s1;
  logic   mode_s1;
  blend_t blend_s2;
  byte_t  red_s3, green_s3, blue_s3;
  logic   mode_s3;

  assign cfg_ready = 1'b1;

  always_comb begin
    map_select_nxt = map_select_r;
    if (cfg_valid && cfg_ready) begin
      map_select_nxt = cfg_data[0];
    end
  end

  assign s3_en     = !s3_valid_r || out_tready;
  assign s2_en     = !s2_valid_r || s3_en;
  assign s1_en     = !s1_valid_r || s2_en;
  assign in_tready = s1_en;

  always_comb begin
    s1_valid_nxt = s1_en ? in_tvalid  : s1_valid_r;
    s2_valid_nxt = s2_en ? s1_valid_r : s2_valid_r;
    s3_valid_nxt = s3_en ? s2_valid_r : s3_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_select_r <= MapViridis;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      s3_valid_r   <= 1'b0;
    end else begin
      map_select_r <= map_select_nxt;
      s1_valid_r   <= s1_valid_nxt;
      s2_valid_r   <= s2_valid_nxt;
      s3_valid_r   <= s3_valid_nxt;
    end
  end

  // Stage one clamps the level into the unit interval.
  cmap_front u_front (
    .clk    (clk),
    .en     (s1_en),
    .level  (in_tdata[LevelWidth-1:0]),
    .mode   (map_select_r),
    .t_r    (t_s1),
    .mode_r (mode_s1)
  );

  // Stage two forms the two weighted key products per channel and the
  // coolwarm ramp values.
  cmap_blend u_blend (
    .clk     (clk),
    .en      (s2_en),
    .t       (t_s1),
    .mode    (mode_s1),
    .blend_r (blend_s2)
  );

  // Stage three sums and clamps each channel (in coolwarm mode it takes the ramp value) and scales it to a byte.
  cmap_quant u_quant (
    .clk     (clk),
    .en      (s3_en),
    .blend   (blend_s2),
    .red_r   (red_s3),
    .green_r (green_s3),
    .blue_r  (blue_s3),
    .mode_r  (mode_s3)
  );

  assign out_tvalid = s3_valid_r;
  assign out_tdata  = {blue_s3, green_s3, red_s3};

  // An accepted word is always held in the first stage on the next cycle.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> s1_valid_r)
    else $error("accepted word did not reach the first stage");

  // A word stuck in the first stage is not dropped.
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_en |=> s1_valid_r)
    else $error("first stage lost a stalled word");

  // A word in the middle stage is either kept or passed to the output.
  a_s2_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |=> s2_valid_r || s3_valid_r)
    else $error("middle stage word vanished");

  // Coolwarm always saturates either red or blue.
  a_coolwarm_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (mode_s3 == MapCoolwarm) |-> (red_s3 == 8'd255) || (blue_s3 == 8'd255))
    else $error("coolwarm colour has neither red nor blue at full scale");

endmodule
